@@ rtl/aifp_pkg.sv @@
// Package for the ASCII integer field parser.
// Holds phase, base and mode types, status codes, register indices and character constants.
// No dependencies.
package aifp_pkg;

    typedef enum logic [5:0] {
        PH_WS     = 6'b000001,
        PH_SIGN   = 6'b000010,
        PH_ZERO   = 6'b000100,
        PH_PREFIX = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_OVER   = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        AB_OCT  = 2'd0,
        AB_DEC  = 2'd1,
        AB_HEX  = 2'd2,
        AB_SDEC = 2'd3
    } base_t;

    typedef enum logic [2:0] {
        MODE_SDEC = 3'd0,
        MODE_AUTO = 3'd1,
        MODE_OCT  = 3'd2,
        MODE_UDEC = 3'd3,
        MODE_HEX  = 3'd4
    } mode_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_DIGITS = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    localparam logic REG_NUMBER_MODE = 1'b0;
    localparam logic REG_FIELD_WIDTH = 1'b1;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_LC_A  = 8'd97;
    localparam logic [7:0] CH_LC_Z  = 8'd122;
    localparam logic [7:0] CH_UC_A  = 8'd65;
    localparam logic [7:0] CH_UC_Z  = 8'd90;
    localparam logic [7:0] CH_LC_X  = 8'd120;
    localparam logic [7:0] CH_UC_X  = 8'd88;

    localparam logic [5:0] DIGIT_NONE = 6'd36;

endpackage

@@ rtl/ascii_integer_field_parser_core.sv @@
// Top level of the ASCII integer field parser.
// Depends on aifp_pkg for phase, base, mode and status definitions.
//
// Usage:
//   Characters enter on the in channel (char_code, end_of_text) with
//   in_valid/in_ready; one transfer per cycle is sustained while no result
//   is stalled. Each character is latched in an input register, then one
//   pass of logic updates the field state and, when a field ends, loads
//   the result register. Results leave on the out channel (parsed_value,
//   parse_status, chars_used, char_taken) with out_valid/out_ready.
//   Throughput: 1 character per cycle while no result is stalled; the state
//   update is a 69-bit multiply-by-base (shifts and adds) and compare.
//   A character that ends no field never waits on the out channel.
//   When the receiver stalls with a result pending, the input register
//   holds and in_ready drops only if the held character ends a field.
//   Configuration: cfg_write with cfg_index 0 (number_mode) or
//   1 (field_width); write only while no field is in progress.
//   Reset: clears both registers and the field state; the parser starts
//   skipping whitespace, mode signed decimal, width unlimited.
module ascii_integer_field_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] parsed_value,
    output logic [1:0]  parse_status,
    output logic [7:0]  chars_used,
    output logic        char_taken
);

    logic [2:0]  mode_reg;
    logic [7:0]  width_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_char_reg;
    logic        s1_eot_reg;

    aifp_pkg::phase_t phase_reg, phase_next;
    aifp_pkg::base_t  base_reg, base_next;
    logic [63:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic [7:0]  used_reg, used_next;

    logic        out_valid_reg;
    logic [63:0] value_reg;
    logic [1:0]  status_reg;
    logic [7:0]  count_reg;
    logic        taken_reg;

    logic        is_ws;
    logic [5:0]  digit;
    logic [4:0]  cur_bv;
    logic [4:0]  acc_bv;
    logic [2:0]  mode_eff;
    logic        do_acc;
    logic        term;
    logic        counted;
    logic        emit;
    logic        taken;
    logic        advance;
    logic [68:0] acc_ext;
    logic [68:0] prod;
    logic [68:0] limit;
    logic        ovf;
    logic [63:0] res_value;
    logic [1:0]  res_status;

    // character classes
    always_comb
    begin
        is_ws = (s1_char_reg == aifp_pkg::CH_SPACE) ||
                (s1_char_reg >= aifp_pkg::CH_TAB && s1_char_reg <= aifp_pkg::CH_CR);
        if (s1_char_reg >= aifp_pkg::CH_ZERO && s1_char_reg <= aifp_pkg::CH_NINE)
        begin
            digit = 6'(s1_char_reg - aifp_pkg::CH_ZERO);
        end
        else if (s1_char_reg >= aifp_pkg::CH_LC_A && s1_char_reg <= aifp_pkg::CH_LC_Z)
        begin
            digit = 6'(s1_char_reg - aifp_pkg::CH_LC_A + 8'd10);
        end
        else if (s1_char_reg >= aifp_pkg::CH_UC_A && s1_char_reg <= aifp_pkg::CH_UC_Z)
        begin
            digit = 6'(s1_char_reg - aifp_pkg::CH_UC_A + 8'd10);
        end
        else
        begin
            digit = aifp_pkg::DIGIT_NONE;
        end
        mode_eff = (mode_reg > 3'(aifp_pkg::MODE_HEX)) ? 3'(aifp_pkg::MODE_UDEC) : mode_reg;
    end

    always_comb
    begin
        case (base_reg)
            aifp_pkg::AB_OCT: cur_bv = 5'd8;
            aifp_pkg::AB_HEX: cur_bv = 5'd16;
            default:          cur_bv = 5'd10;
        endcase
    end

    // phase transitions
    always_comb
    begin
        phase_next = phase_reg;
        base_next  = base_reg;
        neg_next   = neg_reg;
        do_acc     = 1'b0;
        term       = 1'b0;
        counted    = 1'b1;
        case (phase_reg)
            aifp_pkg::PH_WS:
            begin
                if (is_ws)
                begin
                    counted = 1'b0;
                end
                else
                begin
                    case (mode_eff)
                        3'(aifp_pkg::MODE_SDEC):
                        begin
                            base_next = aifp_pkg::AB_SDEC;
                            if (s1_char_reg == aifp_pkg::CH_MINUS)
                            begin
                                neg_next   = 1'b1;
                                phase_next = aifp_pkg::PH_SIGN;
                            end
                            else if (s1_char_reg == aifp_pkg::CH_PLUS)
                            begin
                                phase_next = aifp_pkg::PH_SIGN;
                            end
                            else if (digit < 6'd10)
                            begin
                                do_acc = 1'b1;
                            end
                            else
                            begin
                                term = 1'b1;
                            end
                        end
                        3'(aifp_pkg::MODE_AUTO):
                        begin
                            if (s1_char_reg == aifp_pkg::CH_ZERO)
                            begin
                                base_next  = aifp_pkg::AB_OCT;
                                phase_next = aifp_pkg::PH_ZERO;
                            end
                            else if (digit < 6'd10)
                            begin
                                base_next = aifp_pkg::AB_DEC;
                                do_acc    = 1'b1;
                            end
                            else
                            begin
                                term = 1'b1;
                            end
                        end
                        3'(aifp_pkg::MODE_OCT):
                        begin
                            base_next = aifp_pkg::AB_OCT;
                            if (digit < 6'd8)
                            begin
                                do_acc = 1'b1;
                            end
                            else
                            begin
                                term = 1'b1;
                            end
                        end
                        3'(aifp_pkg::MODE_HEX):
                        begin
                            base_next = aifp_pkg::AB_HEX;
                            if (s1_char_reg == aifp_pkg::CH_ZERO)
                            begin
                                phase_next = aifp_pkg::PH_ZERO;
                            end
                            else if (digit < 6'd16)
                            begin
                                do_acc = 1'b1;
                            end
                            else
                            begin
                                term = 1'b1;
                            end
                        end
                        default:
                        begin
                            base_next = aifp_pkg::AB_DEC;
                            if (digit < 6'd10)
                            begin
                                do_acc = 1'b1;
                            end
                            else
                            begin
                                term = 1'b1;
                            end
                        end
                    endcase
                end
            end
            aifp_pkg::PH_SIGN:
            begin
                if (digit < 6'd10)
                begin
                    do_acc = 1'b1;
                end
                else
                begin
                    term = 1'b1;
                end
            end
            aifp_pkg::PH_ZERO:
            begin
                if (s1_char_reg == aifp_pkg::CH_LC_X || s1_char_reg == aifp_pkg::CH_UC_X)
                begin
                    base_next  = aifp_pkg::AB_HEX;
                    phase_next = aifp_pkg::PH_PREFIX;
                end
                else if (digit < {1'b0, cur_bv})
                begin
                    do_acc = 1'b1;
                end
                else
                begin
                    term = 1'b1;
                end
            end
            aifp_pkg::PH_PREFIX:
            begin
                if (digit < 6'd16)
                begin
                    do_acc = 1'b1;
                end
                else
                begin
                    term = 1'b1;
                end
            end
            aifp_pkg::PH_DIGITS:
            begin
                if (digit < {1'b0, cur_bv})
                begin
                    do_acc = 1'b1;
                end
                else
                begin
                    term = 1'b1;
                end
            end
            aifp_pkg::PH_OVER:
            begin
                if (digit >= {1'b0, cur_bv})
                begin
                    term = 1'b1;
                end
            end
            default:
            begin
                term = 1'b1;
            end
        endcase

        // end of text overrides the character
        if (s1_eot_reg)
        begin
            phase_next = phase_reg;
            base_next  = base_reg;
            neg_next   = neg_reg;
            do_acc     = 1'b0;
            term       = 1'b1;
        end

        // multiply by base and add the digit, check against the limit
        case (base_next)
            aifp_pkg::AB_OCT: acc_bv = 5'd8;
            aifp_pkg::AB_HEX: acc_bv = 5'd16;
            default:          acc_bv = 5'd10;
        endcase
        acc_ext = {5'd0, acc_reg};
        case (acc_bv)
            5'd8:    prod = (acc_ext << 3) + 69'(digit);
            5'd16:   prod = (acc_ext << 4) + 69'(digit);
            default: prod = (acc_ext << 3) + (acc_ext << 1) + 69'(digit);
        endcase
        if (base_next == aifp_pkg::AB_SDEC)
        begin
            limit = neg_next ? {5'd0, 1'b1, 63'd0} : {6'd0, {63{1'b1}}};
        end
        else
        begin
            limit = {5'd0, {64{1'b1}}};
        end
        ovf = prod > limit;

        acc_next = acc_reg;
        if (do_acc)
        begin
            if (ovf)
            begin
                phase_next = aifp_pkg::PH_OVER;
            end
            else
            begin
                acc_next   = prod[63:0];
                phase_next = aifp_pkg::PH_DIGITS;
            end
        end

        used_next = used_reg;
        emit      = term;
        taken     = 1'b0;
        if (!term && counted)
        begin
            used_next = (used_reg == 8'hFF) ? used_reg : used_reg + 8'd1;
            if (width_reg != 8'd0 && used_next >= width_reg)
            begin
                emit  = 1'b1;
                taken = 1'b1;
            end
        end
    end

    // result of a finished field
    always_comb
    begin
        res_value  = 64'd0;
        res_status = aifp_pkg::ST_NO_DIGITS;
        case (phase_next)
            aifp_pkg::PH_ZERO:
            begin
                res_status = aifp_pkg::ST_OK;
            end
            aifp_pkg::PH_DIGITS:
            begin
                res_status = aifp_pkg::ST_OK;
                res_value  = neg_next ? (64'd0 - acc_next) : acc_next;
            end
            aifp_pkg::PH_OVER:
            begin
                res_status = aifp_pkg::ST_OVERFLOW;
                if (base_next == aifp_pkg::AB_SDEC)
                begin
                    res_value = neg_next ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                end
                else
                begin
                    res_value = {64{1'b1}};
                end
            end
            default:
            begin
                res_status = aifp_pkg::ST_NO_DIGITS;
            end
        endcase
    end

    assign advance  = s1_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 3'(aifp_pkg::MODE_SDEC);
            width_reg <= 8'd0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == aifp_pkg::REG_NUMBER_MODE)
            begin
                mode_reg <= cfg_data[2:0];
            end
            else
            begin
                width_reg <= cfg_data;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_char_reg <= char_code;
            s1_eot_reg  <= end_of_text;
        end
    end

    // field state: advance per character, rearm on emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= aifp_pkg::PH_WS;
            base_reg  <= aifp_pkg::AB_OCT;
            acc_reg   <= 64'd0;
            neg_reg   <= 1'b0;
            used_reg  <= 8'd0;
        end
        else if (advance)
        begin
            if (emit)
            begin
                phase_reg <= aifp_pkg::PH_WS;
                base_reg  <= aifp_pkg::AB_OCT;
                acc_reg   <= 64'd0;
                neg_reg   <= 1'b0;
                used_reg  <= 8'd0;
            end
            else
            begin
                phase_reg <= phase_next;
                base_reg  <= base_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                used_reg  <= used_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            value_reg  <= res_value;
            status_reg <= res_status;
            count_reg  <= used_next;
            taken_reg  <= taken;
        end
    end

    assign out_valid    = out_valid_reg;
    assign parsed_value = value_reg;
    assign parse_status = status_reg;
    assign chars_used   = count_reg;
    assign char_taken   = taken_reg;

`ifndef ASSERT_OFF
    a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_status == aifp_pkg::ST_NO_DIGITS |-> parsed_value == 64'd0)
        else $error("no-digits result carries a nonzero value");

    a_taken_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_taken |-> chars_used != 8'd0)
        else $error("taken character not counted");

    a_ws_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == aifp_pkg::PH_WS |-> used_reg == 8'd0 && acc_reg == 64'd0 && !neg_reg)
        else $error("field state not rearmed while skipping whitespace");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && emit)
        else $error("input stalled without a pending result");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> parse_status != 2'd3)
        else $error("undefined status code");
`endif

endmodule

@@ bench/ascii_integer_field_parser_core_test.sv @@
// Self-checking bench for ascii_integer_field_parser_core: directed fields,
// then random text under random register settings, with stalls on both channels.
// Depends on aifp_pkg and the parser RTL; expected fields are predicted in the scoreboard.
`timescale 1ns / 1ps

typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [7:0]  used;
    logic        taken;
} field_result_t;

class parser_scoreboard;
    logic [2:0]        mode_reg;
    logic [7:0]        width_reg;
    aifp_pkg::phase_t  field_phase;
    logic [63:0]       acc;
    aifp_pkg::base_t   base;
    bit                neg;
    logic [7:0]        used;
    field_result_t     expected_fields[$];
    int                mismatches;
    int                results;
    int                n_ok;
    int                n_none;
    int                n_over;

    function new();
        mode_reg = 3'(aifp_pkg::MODE_SDEC);
        width_reg = 8'd0;
        mismatches = 0;
        results = 0;
        n_ok = 0;
        n_none = 0;
        n_over = 0;
        clear_field();
    endfunction

    function void clear_field();
        field_phase = aifp_pkg::PH_WS;
        acc = 64'd0;
        base = aifp_pkg::AB_OCT;
        neg = 1'b0;
        used = 8'd0;
    endfunction

    function int pending();
        return expected_fields.size();
    endfunction

    function void write_reg(logic idx, logic [7:0] data);
        if (idx == aifp_pkg::REG_NUMBER_MODE)
            mode_reg = data[2:0];
        else
            width_reg = data;
    endfunction

    function int unsigned digit_value(logic [7:0] c);
        if (c >= aifp_pkg::CH_ZERO && c <= aifp_pkg::CH_NINE)
            return 32'(c - aifp_pkg::CH_ZERO);
        if (c >= aifp_pkg::CH_LC_A && c <= aifp_pkg::CH_LC_Z)
            return 32'(c - aifp_pkg::CH_LC_A) + 10;
        if (c >= aifp_pkg::CH_UC_A && c <= aifp_pkg::CH_UC_Z)
            return 32'(c - aifp_pkg::CH_UC_A) + 10;
        return 32'(aifp_pkg::DIGIT_NONE);
    endfunction

    function int unsigned radix();
        if (base == aifp_pkg::AB_OCT)
            return 8;
        if (base == aifp_pkg::AB_HEX)
            return 16;
        return 10;
    endfunction

    function void add_digit(int unsigned d);
        logic [63:0] ceiling;
        logic [63:0] b;
        logic [63:0] dw;
        b = 64'(radix());
        dw = 64'(d);
        ceiling = '1;
        if (base == aifp_pkg::AB_SDEC)
            ceiling = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (acc > (ceiling - dw) / b)
            field_phase = aifp_pkg::PH_OVER;
        else
        begin
            acc = acc * b + dw;
            field_phase = aifp_pkg::PH_DIGITS;
        end
    endfunction

    function void close_field(logic taken);
        field_result_t r;
        r.value = 64'd0;
        r.status = aifp_pkg::ST_NO_DIGITS;
        if (field_phase == aifp_pkg::PH_ZERO)
            r.status = aifp_pkg::ST_OK;
        else if (field_phase == aifp_pkg::PH_DIGITS)
        begin
            r.status = aifp_pkg::ST_OK;
            r.value = neg ? 64'd0 - acc : acc;
        end
        else if (field_phase == aifp_pkg::PH_OVER)
        begin
            r.status = aifp_pkg::ST_OVERFLOW;
            if (base == aifp_pkg::AB_SDEC)
                r.value = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            else
                r.value = '1;
        end
        r.used = used;
        r.taken = taken;
        expected_fields.push_back(r);
        clear_field();
    endfunction

    function void note_char(logic [7:0] c, logic eot);
        int unsigned d;
        logic [2:0]  m;
        if (eot)
        begin
            close_field(1'b0);
            return;
        end
        d = digit_value(c);
        case (field_phase)
            aifp_pkg::PH_WS:
            begin
                if (c == aifp_pkg::CH_SPACE || (c >= aifp_pkg::CH_TAB && c <= aifp_pkg::CH_CR))
                    return;
                m = (mode_reg > 3'(aifp_pkg::MODE_HEX)) ? 3'(aifp_pkg::MODE_UDEC) : mode_reg;
                case (m)
                    3'(aifp_pkg::MODE_SDEC):
                    begin
                        base = aifp_pkg::AB_SDEC;
                        if (c == aifp_pkg::CH_MINUS)
                        begin
                            neg = 1'b1;
                            field_phase = aifp_pkg::PH_SIGN;
                        end
                        else if (c == aifp_pkg::CH_PLUS)
                            field_phase = aifp_pkg::PH_SIGN;
                        else if (d < 10)
                            add_digit(d);
                        else
                        begin
                            close_field(1'b0);
                            return;
                        end
                    end
                    3'(aifp_pkg::MODE_AUTO):
                    begin
                        if (c == aifp_pkg::CH_ZERO)
                        begin
                            base = aifp_pkg::AB_OCT;
                            field_phase = aifp_pkg::PH_ZERO;
                        end
                        else if (d < 10)
                        begin
                            base = aifp_pkg::AB_DEC;
                            add_digit(d);
                        end
                        else
                        begin
                            close_field(1'b0);
                            return;
                        end
                    end
                    3'(aifp_pkg::MODE_OCT):
                    begin
                        base = aifp_pkg::AB_OCT;
                        if (d < 8)
                            add_digit(d);
                        else
                        begin
                            close_field(1'b0);
                            return;
                        end
                    end
                    3'(aifp_pkg::MODE_UDEC):
                    begin
                        base = aifp_pkg::AB_DEC;
                        if (d < 10)
                            add_digit(d);
                        else
                        begin
                            close_field(1'b0);
                            return;
                        end
                    end
                    default:
                    begin
                        base = aifp_pkg::AB_HEX;
                        if (c == aifp_pkg::CH_ZERO)
                            field_phase = aifp_pkg::PH_ZERO;
                        else if (d < 16)
                            add_digit(d);
                        else
                        begin
                            close_field(1'b0);
                            return;
                        end
                    end
                endcase
            end
            aifp_pkg::PH_SIGN:
            begin
                if (d < 10)
                    add_digit(d);
                else
                begin
                    close_field(1'b0);
                    return;
                end
            end
            aifp_pkg::PH_ZERO:
            begin
                if (c == aifp_pkg::CH_LC_X || c == aifp_pkg::CH_UC_X)
                begin
                    base = aifp_pkg::AB_HEX;
                    field_phase = aifp_pkg::PH_PREFIX;
                end
                else if (d < radix())
                    add_digit(d);
                else
                begin
                    close_field(1'b0);
                    return;
                end
            end
            aifp_pkg::PH_PREFIX:
            begin
                if (d < 16)
                    add_digit(d);
                else
                begin
                    close_field(1'b0);
                    return;
                end
            end
            aifp_pkg::PH_DIGITS:
            begin
                if (d < radix())
                    add_digit(d);
                else
                begin
                    close_field(1'b0);
                    return;
                end
            end
            aifp_pkg::PH_OVER:
            begin
                if (d >= radix())
                begin
                    close_field(1'b0);
                    return;
                end
            end
            default:
            begin
                close_field(1'b0);
                return;
            end
        endcase
        if (used != 8'hFF)
            used++;
        if (width_reg != 8'd0 && used >= width_reg)
            close_field(1'b1);
    endfunction

    function void check_result(logic [63:0] value, logic [1:0] status,
                               logic [7:0] used_n, logic taken);
        field_result_t want;
        if (expected_fields.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result: value %h status %0d used %0d taken %0d",
                         $time, value, status, used_n, taken);
            return;
        end
        want = expected_fields.pop_front();
        results++;
        if (want.status == aifp_pkg::ST_OK)
            n_ok++;
        else if (want.status == aifp_pkg::ST_NO_DIGITS)
            n_none++;
        else
            n_over++;
        if (value !== want.value || status !== want.status ||
            used_n !== want.used || taken !== want.taken)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: field %0d expected value %h status %0d used %0d taken %0d",
                         $time, results, want.value, want.status, want.used, want.taken);
                $display("%0t: field %0d got      value %h status %0d used %0d taken %0d",
                         $time, results, value, status, used_n, taken);
            end
        end
    endfunction
endclass

module ascii_integer_field_parser_core_test;

    localparam logic [2:0] MODE_RESERVED_TOP = 3'd7;
    localparam int ITEM_TARGET   = 1550;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_code;
    logic        end_of_text;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] parsed_value;
    logic [1:0]  parse_status;
    logic [7:0]  chars_used;
    logic        char_taken;

    parser_scoreboard sb;
    bit steady;
    bit hold_request;
    int sent;
    int settings;
    int quiet;

    ascii_integer_field_parser_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .parsed_value (parsed_value),
        .parse_status (parse_status),
        .chars_used   (chars_used),
        .char_taken   (char_taken)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? aifp_pkg::CH_SPACE : 8'(aifp_pkg::CH_TAB + r);
    endfunction

    function automatic logic [7:0] digit_char(int unsigned radix_n);
        int unsigned v;
        v = $urandom_range(0, radix_n - 1);
        if (v < 10)
            return 8'(aifp_pkg::CH_ZERO + v);
        return 8'(($urandom_range(0, 1) ? aifp_pkg::CH_LC_A : aifp_pkg::CH_UC_A) + v - 10);
    endfunction

    function automatic string limit_text(logic [2:0] m);
        string opts[$];
        case (m)
            3'(aifp_pkg::MODE_SDEC): opts = {"-9223372036854775808", "9223372036854775807",
                                            "-9223372036854775809", "+9223372036854775808",
                                            "-00009223372036854775807"};
            3'(aifp_pkg::MODE_AUTO): opts = {"18446744073709551615", "0xFFFFFFFFFFFFFFFF",
                                            "0x10000000000000000", "01777777777777777777777",
                                            "02000000000000000000000"};
            3'(aifp_pkg::MODE_OCT):  opts = {"1777777777777777777777", "2000000000000000000000"};
            3'(aifp_pkg::MODE_HEX):  opts = {"ffffffffffffffff", "0X10000000000000000",
                                            "0x7fffffffffffffff"};
            default:                 opts = {"18446744073709551615", "18446744073709551616"};
        endcase
        return opts[$urandom_range(0, opts.size() - 1)];
    endfunction

    task automatic send_item(logic [7:0] c, logic eot);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= c;
        end_of_text <= eot;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic close_text();
        logic [7:0] b;
        b = 8'($urandom);
        send_item(b, 1'b1);
        in_valid <= 1'b0;
    endtask

    task automatic set_config(logic [2:0] m, logic [7:0] w);
        logic [4:0] junk;
        junk = 5'($urandom);
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= aifp_pkg::REG_NUMBER_MODE;
        cfg_data <= {junk, m};
        @(posedge clk);
        cfg_index <= aifp_pkg::REG_FIELD_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(aifp_pkg::REG_NUMBER_MODE, {junk, m});
        sb.write_reg(aifp_pkg::REG_FIELD_WIDTH, w);
        settings++;
    endtask

    task automatic send_field(logic [2:0] m);
        int unsigned radix_n;
        int n;
        int r;
        logic [7:0] b;
        radix_n = (m == 3'(aifp_pkg::MODE_OCT)) ? 8 : (m == 3'(aifp_pkg::MODE_HEX)) ? 16 : 10;
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) send_item(blank_char(), 1'b0);
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            repeat ($urandom_range(1, 4))
            begin
                b = 8'($urandom);
                send_item(b, 1'b0);
            end
            return;
        end
        if (r < 20)
            send_text(limit_text(m));
        else
        begin
            if (m == 3'(aifp_pkg::MODE_SDEC) || $urandom_range(0, 9) == 0)
            begin
                r = $urandom_range(0, 2);
                if (r == 1)
                    send_item(aifp_pkg::CH_MINUS, 1'b0);
                else if (r == 2)
                    send_item(aifp_pkg::CH_PLUS, 1'b0);
            end
            if ((m == 3'(aifp_pkg::MODE_AUTO) || m == 3'(aifp_pkg::MODE_HEX)) &&
                $urandom_range(0, 2) == 0)
            begin
                send_item(aifp_pkg::CH_ZERO, 1'b0);
                send_item($urandom_range(0, 1) ? aifp_pkg::CH_LC_X : aifp_pkg::CH_UC_X, 1'b0);
                radix_n = 16;
            end
            else if (m == 3'(aifp_pkg::MODE_AUTO) && $urandom_range(0, 3) == 0)
            begin
                send_item(aifp_pkg::CH_ZERO, 1'b0);
                radix_n = 8;
            end
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(14, 24);
            repeat (n)
                send_item(($urandom_range(0, 29) == 0) ? digit_char(36) : digit_char(radix_n),
                          1'b0);
        end
        r = $urandom_range(0, 9);
        b = 8'($urandom);
        if (r < 4)
            send_item(blank_char(), 1'b0);
        else if (r < 6)
            send_item(8'($urandom_range(33, 47)), 1'b0);
        else if (r < 8)
            send_item(b, 1'b0);
        else
            send_item(b, 1'b1);
    endtask

    // receiver: random ready pattern, one long hold-off on request
    initial
    begin
        int g;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            g = gap_len();
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(parsed_value, parse_status, chars_used, char_taken);
        if (rst_n && in_valid && in_ready)
            sb.note_char(char_code, end_of_text);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("[ascii_integer_field_parser_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] m;
        logic [7:0] w;
        int round;
        int r;
        int nf;
        sb = new();
        steady = 1'b0;
        hold_request = 1'b0;
        sent = 0;
        settings = 0;
        quiet = 0;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= aifp_pkg::REG_NUMBER_MODE;
        cfg_data <= 8'd0;
        in_valid <= 1'b0;
        char_code <= 8'd0;
        end_of_text <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        set_config(3'(aifp_pkg::MODE_SDEC), 8'd0);
        send_item(8'h00, 1'b1);
        send_text(" -7,+");
        send_item(8'hFF, 1'b1);
        send_item(8'hFF, 1'b0);
        close_text();

        set_config(3'(aifp_pkg::MODE_AUTO), 8'd0);
        send_text("0");
        send_item(8'hFF, 1'b1);
        send_text("0x");
        send_item(8'h00, 1'b1);
        send_text("017\n");
        close_text();

        set_config(3'(aifp_pkg::MODE_HEX), 8'd3);
        send_text("0XaFz");
        close_text();

        set_config(MODE_RESERVED_TOP, 8'd1);
        send_text("-9");
        close_text();

        set_config(3'(aifp_pkg::MODE_OCT), 8'd255);
        send_text("877");
        close_text();

        round = 0;
        while (sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                m = 3'($urandom_range(aifp_pkg::MODE_HEX + 1, MODE_RESERVED_TOP));
            else
                m = 3'($urandom_range(aifp_pkg::MODE_SDEC, aifp_pkg::MODE_HEX));
            r = $urandom_range(0, 99);
            if (r < 55)
                w = 8'd0;
            else if (r < 80)
                w = 8'($urandom_range(1, 8));
            else if (r < 92)
                w = 8'($urandom_range(9, 30));
            else if (r < 96)
                w = 8'd255;
            else
                w = 8'd1;
            set_config(m, w);
            steady = (round == 1) || ($urandom_range(0, 4) == 0);
            if (round == 2)
                hold_request = 1'b1;
            nf = (round == 2) ? 40 : $urandom_range(5, 25);
            for (int i = 0; i < nf && (round == 2 || sent < ITEM_TARGET); i++)
                send_field(m);
            close_text();
            round++;
        end

        do @(posedge clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d characters under %0d register settings, one long output hold-off",
                 sent, settings);
        $display("%0d fields: %0d ok, %0d without digits, %0d overflowed; %0d mismatches",
                 sb.results, sb.n_ok, sb.n_none, sb.n_over, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ascii_integer_field_parser_core] OK");
        else
            $display("[ascii_integer_field_parser_core] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/aifp_pkg.sv
rtl/ascii_integer_field_parser_core.sv
bench/ascii_integer_field_parser_core_test.sv
